### hdl/dtp_pkg.sv
`default_nettype none

package dtp_pkg;

	localparam int CODE_UNIT_BITS = 16;

	localparam logic [CODE_UNIT_BITS-1:0] CHAR_ZERO  = CODE_UNIT_BITS'(8'h30);
	localparam logic [CODE_UNIT_BITS-1:0] CHAR_NINE  = CODE_UNIT_BITS'(8'h39);
	localparam logic [CODE_UNIT_BITS-1:0] CHAR_PLUS  = CODE_UNIT_BITS'(8'h2b);
	localparam logic [CODE_UNIT_BITS-1:0] CHAR_MINUS = CODE_UNIT_BITS'(8'h2d);

	localparam logic [4:0] SIGNED_DIGITS   = 5'd19;
	localparam logic [4:0] UNSIGNED_DIGITS = 5'd20;

	// largest accumulator that can still take one more digit, and its top digit
	localparam logic [63:0] ACC_TOP       = 64'd1844674407370955161;
	localparam logic [3:0]  ACC_TOP_DIGIT = 4'd5;

	localparam logic [63:0] INT64_MIN_MAG = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [63:0] acc;
		logic [4:0]  cnt;
		logic        neg;
		logic        failed;
		logic        at_start;
	} parse_st_t;

	localparam parse_st_t PARSE_CLEAR = '{
		acc: 64'd0, cnt: 5'd0, neg: 1'b0, failed: 1'b0, at_start: 1'b1
	};

endpackage

`default_nettype wire

### hdl/dtp_step.sv
`default_nettype none

module dtp_step (
	input  var dtp_pkg::parse_st_t                    st,
	input  wire logic [dtp_pkg::CODE_UNIT_BITS-1:0]   code_unit,
	input  wire logic                                 no_char,
	input  wire logic                                 signed_mode,
	output dtp_pkg::parse_st_t                        st_next
);
	import dtp_pkg::*;

	logic        is_sign;
	logic        is_digit;
	logic [3:0]  digit;
	logic [4:0]  limit;
	logic        ovf;
	logic [63:0] acc_x10;

	assign is_sign  = (code_unit == CHAR_PLUS) || (code_unit == CHAR_MINUS);
	assign is_digit = (code_unit >= CHAR_ZERO) && (code_unit <= CHAR_NINE);
	assign digit    = 4'(code_unit - CHAR_ZERO);
	assign limit    = signed_mode ? SIGNED_DIGITS : UNSIGNED_DIGITS;
	assign ovf      = (st.acc > ACC_TOP) || ((st.acc == ACC_TOP) && (digit > ACC_TOP_DIGIT));
	// times ten as shift and add
	assign acc_x10  = {st.acc[60:0], 3'b000} + {st.acc[62:0], 1'b0};

	always_comb begin
		st_next = st;
		if (!no_char) begin
			st_next.at_start = 1'b0;
			if (!st.failed) begin
				if (st.at_start && signed_mode && is_sign) begin
					st_next.neg = (code_unit == CHAR_MINUS);
				end else if (!is_digit || (st.cnt >= limit) || ovf) begin
					st_next.failed = 1'b1;
				end else begin
					st_next.acc = acc_x10 + {60'd0, digit};
					st_next.cnt = st.cnt + 5'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

### hdl/decimal_text_to_int64_parser.sv
`default_nettype none

// Parses a decimal string that arrives one code unit per transfer on the char
// channel and gives one result transfer (value_bits, status) for the item marked
// last. A new character is taken every cycle unless char_stall is high; the result
// of a string passes the input register, then the result register, before it shows
// on the result channel, and a last item waits in the input register only while an
// earlier result is held by result_stall. Throughput is one character per cycle when
// not stalled, set by the multiply-by-ten shift-add and its overflow compare, which
// run combinationally between the input register and the string state. signed_mode
// (reset 1) selects int64 with an optional leading sign, or uint64; write it only
// while no string is in progress. A failed parse returns zero with status 1.
module decimal_text_to_int64_parser (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic                                cfg_wdata,
	input  wire logic                                char_valid,
	output logic                                     char_stall,
	input  wire logic [dtp_pkg::CODE_UNIT_BITS-1:0]  code_unit,
	input  wire logic                                no_char,
	input  wire logic                                last,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic [63:0]                              value_bits,
	output logic                                     status
);
	import dtp_pkg::*;

	logic                      signed_mode_q;
	logic                      valid_s1;
	logic [CODE_UNIT_BITS-1:0] code_s1;
	logic                      no_char_s1;
	logic                      last_s1;
	parse_st_t                 st_q;
	parse_st_t                 st_step;
	logic                      adv;
	logic                      fin_bad;
	logic [63:0]               fin_val;
	logic                      out_valid_q;
	logic [63:0]               value_q;
	logic                      status_q;

	dtp_step u_step (
		.st          (st_q),
		.code_unit   (code_s1),
		.no_char     (no_char_s1),
		.signed_mode (signed_mode_q),
		.st_next     (st_step)
	);

	// item in stage one leaves unless it needs the result register and that is held
	assign adv        = valid_s1 && (!last_s1 || !out_valid_q || !result_stall);
	assign char_stall = valid_s1 && !adv;

	always_comb begin
		fin_bad = st_step.failed;
		fin_val = st_step.acc;
		if (!st_step.failed && signed_mode_q) begin
			if (st_step.acc[63] && (!st_step.neg || (st_step.acc != INT64_MIN_MAG))) begin
				fin_bad = 1'b1;
			end else if (st_step.neg) begin
				fin_val = 64'd0 - st_step.acc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b1;
		end else if (cfg_we) begin
			signed_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			code_s1    <= code_unit;
			no_char_s1 <= no_char;
			last_s1    <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PARSE_CLEAR;
		end else if (adv) begin
			st_q <= last_s1 ? PARSE_CLEAR : st_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (adv && last_s1) || (out_valid_q && result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			value_q  <= fin_bad ? 64'd0 : fin_val;
			status_q <= fin_bad;
		end
	end

	assign result_valid = out_valid_q;
	assign value_bits   = value_q;
	assign status       = status_q;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q) |-> (value_q == 64'd0))
		else $error("failed result carries a nonzero value");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.cnt <= UNSIGNED_DIGITS)
		else $error("digit count beyond twenty");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (st_q.at_start && !st_q.failed && (st_q.cnt == 5'd0)))
		else $error("string state not cleared after last");

	a_start_empty: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.at_start |-> ((st_q.acc == 64'd0) && (st_q.cnt == 5'd0) && !st_q.neg))
		else $error("start state holds digits");

endmodule

`default_nettype wire
